// ----- src/hex_header_stream_deframer_assert.svh -----
// ----------------------------------------------------------------------------
// hex header stream deframer assertion macros
// concurrent checks clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef HEX_HEADER_STREAM_DEFRAMER_ASSERT_SVH
`define HEX_HEADER_STREAM_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// property that holds in the same cycle
`define HHSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// property that holds in the next cycle
`define HHSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HHSD_ASSERT_NOW(label, ante, cons, msg)
`define HHSD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- src/hhsd_pkg.sv -----
// ----------------------------------------------------------------------------
// hhsd_pkg
// shared types and constants of the hex header stream deframer
// ----------------------------------------------------------------------------
`default_nettype none

package hhsd_pkg;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_PAYLOAD     = 2'd0;
  localparam status_t STATUS_LENGTH_BAD  = 2'd1;
  localparam status_t STATUS_EMPTY_FRAME = 2'd2;
  localparam status_t STATUS_DROPPED     = 2'd3;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [3:0] DIGIT_TEN    = 4'd10;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [7:0] channel_index;
    logic       last_of_frame;
    status_t    status;
  } result_t;

endpackage

`default_nettype wire

// ----- src/hhsd_nibble_decode.sv -----
// ----------------------------------------------------------------------------
// hhsd_nibble_decode
// maps an ascii hex digit of either case to its nibble value
// ----------------------------------------------------------------------------
`default_nettype none

module hhsd_nibble_decode (
  input  wire logic [7:0] rx_byte,
  output logic            is_hex,
  output logic [3:0]      nibble
);

  logic [7:0] diff;

  always_comb begin
    diff   = 8'd0;
    is_hex = 1'b0;
    nibble = 4'd0;
    if (rx_byte inside {[hhsd_pkg::CHAR_ZERO:hhsd_pkg::CHAR_NINE]}) begin
      diff   = rx_byte - hhsd_pkg::CHAR_ZERO;
      is_hex = 1'b1;
      nibble = diff[3:0];
    end else if (rx_byte inside {[hhsd_pkg::CHAR_LOWER_A:hhsd_pkg::CHAR_LOWER_F]}) begin
      diff   = rx_byte - hhsd_pkg::CHAR_LOWER_A;
      is_hex = 1'b1;
      nibble = diff[3:0] + hhsd_pkg::DIGIT_TEN;
    end else if (rx_byte inside {[hhsd_pkg::CHAR_UPPER_A:hhsd_pkg::CHAR_UPPER_F]}) begin
      diff   = rx_byte - hhsd_pkg::CHAR_UPPER_A;
      is_hex = 1'b1;
      nibble = diff[3:0] + hhsd_pkg::DIGIT_TEN;
    end
  end

endmodule

`default_nettype wire

// ----- src/hhsd_parser.sv -----
// ----------------------------------------------------------------------------
// hhsd_parser
// header and payload tracking for one registered byte per cycle while advance is high
// ----------------------------------------------------------------------------
`default_nettype none

module hhsd_parser #(
  parameter int LENGTH_DIGITS  = 4,
  parameter int CHANNEL_DIGITS = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  output hhsd_pkg::result_t     res
);

  localparam int LW  = 4 * LENGTH_DIGITS;
  localparam int CW  = 4 * CHANNEL_DIGITS;
  localparam int HL  = LENGTH_DIGITS + CHANNEL_DIGITS;
  localparam int HCW = $clog2(HL);

  logic           in_payload, in_payload_next;
  logic [HCW-1:0] header_count, header_count_next;
  logic [LW-1:0]  length_accum, length_accum_next;
  logic [CW-1:0]  channel_accum, channel_accum_next;
  logic           length_bad, length_bad_next;
  logic           channel_bad, channel_bad_next;
  logic [LW-1:0]  payload_count, payload_count_next;

  logic           is_hex;
  logic [3:0]     nibble;
  logic           is_len_digit;
  logic [LW+3:0]  len_shift;
  logic [CW+3:0]  chan_shift;
  logic [CW+7:0]  chan_ext;
  logic [CW+7:0]  chan_ext_next;
  logic [LW-1:0]  count_inc;
  logic           last;

  hhsd_nibble_decode u_decode (
    .rx_byte (rx_byte),
    .is_hex  (is_hex),
    .nibble  (nibble)
  );

  assign is_len_digit = header_count < HCW'(LENGTH_DIGITS);
  assign len_shift    = {length_accum, nibble};
  assign chan_shift   = {channel_accum, nibble};
  assign chan_ext     = {8'd0, channel_accum};
  assign count_inc    = payload_count + LW'(1);
  assign last         = count_inc == length_accum;

  always_comb begin
    in_payload_next    = in_payload;
    header_count_next  = header_count;
    length_accum_next  = length_accum;
    channel_accum_next = channel_accum;
    length_bad_next    = length_bad;
    channel_bad_next   = channel_bad;
    payload_count_next = payload_count;
    chan_ext_next      = chan_ext;
    res_valid          = 1'b0;
    res                = '0;

    if (!in_payload) begin
      if (is_len_digit) begin
        if (!is_hex) length_bad_next = 1'b1;
        else length_accum_next = len_shift[LW-1:0];
      end else begin
        if (!is_hex) channel_bad_next = 1'b1;
        else channel_accum_next = chan_shift[CW-1:0];
      end
      chan_ext_next = {8'd0, channel_accum_next};

      if (header_count != HCW'(HL - 1)) begin
        header_count_next = header_count + HCW'(1);
      end else if (length_bad_next) begin
        res_valid  = 1'b1;
        res.status = hhsd_pkg::STATUS_LENGTH_BAD;
      end else if (length_accum_next == '0) begin
        res_valid         = 1'b1;
        res.status        = hhsd_pkg::STATUS_EMPTY_FRAME;
        res.channel_index = channel_bad_next ? 8'd0 : chan_ext_next[7:0];
      end else begin
        in_payload_next    = 1'b1;
        payload_count_next = '0;
        header_count_next  = '0;
      end

      // header finished without a payload: start hunting again
      if (header_count == HCW'(HL - 1) && (length_bad_next || length_accum_next == '0)) begin
        header_count_next  = '0;
        length_accum_next  = '0;
        channel_accum_next = '0;
        length_bad_next    = 1'b0;
        channel_bad_next   = 1'b0;
      end
    end else begin
      payload_count_next = count_inc;
      if (!channel_bad) begin
        res_valid           = 1'b1;
        res.payload_byte    = rx_byte;
        res.channel_index   = chan_ext[7:0];
        res.last_of_frame   = last;
        res.status          = hhsd_pkg::STATUS_PAYLOAD;
      end else if (last) begin
        res_valid         = 1'b1;
        res.last_of_frame = 1'b1;
        res.status        = hhsd_pkg::STATUS_DROPPED;
      end
      if (last) begin
        in_payload_next    = 1'b0;
        payload_count_next = '0;
        header_count_next  = '0;
        length_accum_next  = '0;
        channel_accum_next = '0;
        length_bad_next    = 1'b0;
        channel_bad_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload    <= 1'b0;
      header_count  <= '0;
      length_accum  <= '0;
      channel_accum <= '0;
      length_bad    <= 1'b0;
      channel_bad   <= 1'b0;
      payload_count <= '0;
    end else if (advance) begin
      in_payload    <= in_payload_next;
      header_count  <= header_count_next;
      length_accum  <= length_accum_next;
      channel_accum <= channel_accum_next;
      length_bad    <= length_bad_next;
      channel_bad   <= channel_bad_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/hhsd_out_reg.sv -----
// ----------------------------------------------------------------------------
// hhsd_out_reg
// result register holding one result until the downstream side takes it
// ----------------------------------------------------------------------------
`default_nettype none

module hhsd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire hhsd_pkg::result_t res,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             payload_byte,
  output logic [7:0]             channel_index,
  output logic                   last_of_frame,
  output logic [1:0]             status
);

  hhsd_pkg::result_t held;

  assign free          = !out_valid || out_ready;
  assign payload_byte  = held.payload_byte;
  assign channel_index = held.channel_index;
  assign last_of_frame = held.last_of_frame;
  assign status        = held.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

endmodule

`default_nettype wire

// ----- src/hex_header_stream_deframer.sv -----
// ----------------------------------------------------------------------------
// hex_header_stream_deframer
// splits a byte stream into frames with an ascii hex length and channel header
// ----------------------------------------------------------------------------
// Takes one byte per clock on the rx_byte channel and keeps taking one per
// clock as long as results are drained. Each accepted byte lands in an input
// register; the parser decodes it there and, once the output register is free,
// updates the frame state and loads any result into the output register,
// where it is held until the downstream side takes it. Header bytes
// give no result; a bad length header gives status 1, a zero-length frame
// status 2, and a frame whose channel is not hex is swallowed and reported
// with status 3 on its last byte. A request stalls in the input register only
// while the output register is full and not being taken.
`default_nettype none

`include "hex_header_stream_deframer_assert.svh"

module hex_header_stream_deframer #(
  parameter int LENGTH_DIGITS  = 4,
  parameter int CHANNEL_DIGITS = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      payload_byte,
  output logic [7:0]      channel_index,
  output logic            last_of_frame,
  output logic [1:0]      status
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_advance;
  logic              out_free;
  logic              res_valid;
  logic              push;
  hhsd_pkg::result_t res;

  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || s1_advance;
  assign push       = s1_advance && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  hhsd_parser #(
    .LENGTH_DIGITS  (LENGTH_DIGITS),
    .CHANNEL_DIGITS (CHANNEL_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_advance),
    .rx_byte   (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  hhsd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .channel_index (channel_index),
    .last_of_frame (last_of_frame),
    .status        (status)
  );

  // a dropped frame is only reported on its final byte
  `HHSD_ASSERT_NOW(a_drop_on_last,
    out_valid && status == hhsd_pkg::STATUS_DROPPED, last_of_frame,
    "dropped frame report without last flag")

  // only payload results carry a data byte
  `HHSD_ASSERT_NOW(a_no_data_on_report,
    out_valid && status != hhsd_pkg::STATUS_PAYLOAD, payload_byte == 8'd0,
    "report carries a data byte")

  // a new result never overwrites one still waiting
  `HHSD_ASSERT_NOW(a_no_overwrite, push && out_valid, out_ready,
    "result pushed over a pending one")

  // a pushed result is shown in the next cycle
  `HHSD_ASSERT_NEXT(a_push_shows, push, out_valid, "pushed result not presented")

endmodule

`default_nettype wire

// ----- dv/hex_header_stream_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// hex_header_stream_deframer_tb
// Self-checking bench for the hex header deframer. It first walks a short
// table of directed bytes, then sends random frames: mostly well-formed, some
// with bad length or channel digits, some empty. Both handshakes idle at
// random. Each accepted byte runs through a local deframer model, and every
// result from the block is compared field by field with the oldest expected
// result.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_header_stream_deframer_tb;

  localparam int LEN_DIGITS     = 4;
  localparam int CHAN_DIGITS    = 2;
  localparam int HDR_LEN        = LEN_DIGITS + CHAN_DIGITS;
  localparam int DIR_ROWS       = 27;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int HOLD_AT        = DIR_ROWS + 300;
  localparam int HOLD_ITEMS     = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int PAUSE_AT       = DIR_ROWS + 700;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam hhsd_pkg::result_t NONE = '0;

  typedef struct {
    logic [7:0]        rx;
    bit                typed;
    hhsd_pkg::result_t res;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] payload_byte;
  logic [7:0] channel_index;
  logic       last_of_frame;
  logic [1:0] status;

  // byte stream to send, with typed-in results for some directed rows
  logic [7:0]        rx_stream[$];
  bit                rx_typed[$];
  hhsd_pkg::result_t rx_typed_res[$];
  dir_row_t          dir_table[DIR_ROWS];

  hhsd_pkg::result_t pending_results[$];
  int                send_idx;
  int                mismatch_count;
  int                idle_cycles;
  bit                rst_done;
  bit                hold_req;
  bit                draining;

  // deframer model state
  bit                        in_frame;
  logic [2:0]                hdr_cnt;
  logic [4*LEN_DIGITS-1:0]   len_acc;
  logic [4*CHAN_DIGITS-1:0]  chan_acc;
  bit                        len_bad;
  bit                        chan_bad;
  logic [4*LEN_DIGITS-1:0]   pay_cnt;

  hex_header_stream_deframer #(
    .LENGTH_DIGITS  (LEN_DIGITS),
    .CHANNEL_DIGITS (CHAN_DIGITS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .channel_index (channel_index),
    .last_of_frame (last_of_frame),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // nibble value, or 16 when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= hhsd_pkg::CHAR_ZERO && c <= hhsd_pkg::CHAR_NINE)
      return {1'b0, 4'(c - hhsd_pkg::CHAR_ZERO)};
    if (c >= hhsd_pkg::CHAR_LOWER_A && c <= hhsd_pkg::CHAR_LOWER_F)
      return {1'b0, 4'(c - hhsd_pkg::CHAR_LOWER_A + hhsd_pkg::DIGIT_TEN)};
    if (c >= hhsd_pkg::CHAR_UPPER_A && c <= hhsd_pkg::CHAR_UPPER_F)
      return {1'b0, 4'(c - hhsd_pkg::CHAR_UPPER_A + hhsd_pkg::DIGIT_TEN)};
    return 5'h10;
  endfunction

  function automatic void restart_hunt();
    hdr_cnt  = '0;
    len_acc  = '0;
    chan_acc = '0;
    len_bad  = 1'b0;
    chan_bad = 1'b0;
  endfunction

  // advances the model by one byte; returns 1 when a result is due
  function automatic bit deframe_byte(input logic [7:0] b, output hhsd_pkg::result_t res);
    logic [4:0] d;
    bit         last;
    res = '0;
    if (!in_frame) begin
      d = hex_value(b);
      if (hdr_cnt < LEN_DIGITS) begin
        if (d[4]) len_bad = 1'b1;
        else len_acc = (len_acc << 4) | d[3:0];
      end else begin
        if (d[4]) chan_bad = 1'b1;
        else chan_acc = (chan_acc << 4) | d[3:0];
      end
      hdr_cnt = hdr_cnt + 3'd1;
      if (hdr_cnt < HDR_LEN) return 1'b0;
      if (len_bad) begin
        restart_hunt();
        res.status = hhsd_pkg::STATUS_LENGTH_BAD;
        return 1'b1;
      end
      if (len_acc == '0) begin
        res.channel_index = chan_bad ? 8'd0 : 8'(chan_acc);
        res.status        = hhsd_pkg::STATUS_EMPTY_FRAME;
        restart_hunt();
        return 1'b1;
      end
      in_frame = 1'b1;
      pay_cnt  = '0;
      hdr_cnt  = '0;
      return 1'b0;
    end
    pay_cnt = pay_cnt + 1'b1;
    last    = (pay_cnt == len_acc);
    if (!chan_bad) begin
      res.payload_byte  = b;
      res.channel_index = 8'(chan_acc);
      res.last_of_frame = last;
      res.status        = hhsd_pkg::STATUS_PAYLOAD;
    end else if (last) begin
      res.last_of_frame = 1'b1;
      res.status        = hhsd_pkg::STATUS_DROPPED;
    end
    if (last) begin
      in_frame = 1'b0;
      pay_cnt  = '0;
      restart_hunt();
    end
    return !chan_bad || last;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // non-hex byte, biased toward the neighbors of the digit ranges
  function automatic logic [7:0] non_hex_byte();
    logic [7:0] near_miss[8] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, 8'h00, 8'hFF};
    logic [7:0] c;
    if ($urandom_range(0, 1)) return near_miss[$urandom_range(0, 7)];
    do begin
      c = 8'($urandom_range(0, 255));
    end while (hex_value(c) != 5'h10);
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    rx_typed.push_back(1'b0);
    rx_typed_res.push_back(NONE);
  endtask

  // hex field, msb first, random letter case; one digit spoiled when bad
  task automatic add_field(input logic [15:0] value, input int digits, input bit bad);
    int         bad_pos;
    logic [3:0] nib;
    logic [7:0] ch;
    bad_pos = bad ? $urandom_range(0, digits - 1) : -1;
    for (int k = digits - 1; k >= 0; k--) begin
      nib = value[4*k +: 4];
      if (k == bad_pos) ch = non_hex_byte();
      else if (nib < hhsd_pkg::DIGIT_TEN) ch = hhsd_pkg::CHAR_ZERO + 8'(nib);
      else if ($urandom_range(0, 1))
        ch = hhsd_pkg::CHAR_LOWER_A + 8'(nib - hhsd_pkg::DIGIT_TEN);
      else ch = hhsd_pkg::CHAR_UPPER_A + 8'(nib - hhsd_pkg::DIGIT_TEN);
      add_byte(ch);
    end
  endtask

  // model and compare
  always @(posedge clk) begin : scoreboard
    hhsd_pkg::result_t want;
    bit                hit;
    if (!rst) begin
      if (in_valid && in_ready) begin
        hit = deframe_byte(rx_byte, want);
        if (rx_typed[send_idx]) pending_results.push_back(rx_typed_res[send_idx]);
        else if (hit) pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: status %0d", status);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte);
            mismatch_count++;
          end
          if (channel_index !== want.channel_index) begin
            $error("channel_index: expected %0h, got %0h", want.channel_index, channel_index);
            mismatch_count++;
          end
          if (last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, got %0b", want.last_of_frame, last_of_frame);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("hex_header_stream_deframer_tb failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    wait (rst_done);
    forever begin
      if (draining) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
        out_ready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
        repeat (n) @(negedge clk);
      end
    end
  end

  initial begin : main
    int r;
    int len;
    int gap;
    int calm;
    rst            = 1'b1;
    in_valid       = 1'b0;
    rx_byte        = 8'h00;
    send_idx       = 0;
    mismatch_count = 0;
    rst_done       = 1'b0;
    hold_req       = 1'b0;
    draining       = 1'b0;
    calm           = 0;
    in_frame       = 1'b0;
    pay_cnt        = '0;
    restart_hunt();

    dir_table = '{
      // one-byte frame, channel ff, payload ff
      '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE}, '{"1", 1'b0, NONE},
      '{"F", 1'b0, NONE}, '{"f", 1'b0, NONE},
      '{8'hFF, 1'b1, '{8'hFF, 8'hFF, 1'b1, hhsd_pkg::STATUS_PAYLOAD}},
      // empty frame with a bad channel digit reports channel 0
      '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE},
      '{"g", 1'b0, NONE},
      '{"0", 1'b1, '{8'h00, 8'h00, 1'b0, hhsd_pkg::STATUS_EMPTY_FRAME}},
      // length digit not hex
      '{"F", 1'b0, NONE}, '{8'h00, 1'b0, NONE}, '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE},
      '{"0", 1'b0, NONE},
      '{"0", 1'b1, '{8'h00, 8'h00, 1'b0, hhsd_pkg::STATUS_LENGTH_BAD}},
      // bad channel: payload swallowed, dropped on the last byte
      '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE}, '{"0", 1'b0, NONE}, '{"2", 1'b0, NONE},
      '{"/", 1'b0, NONE}, '{":", 1'b0, NONE}, '{8'h00, 1'b0, NONE},
      '{8'h80, 1'b1, '{8'h00, 8'h00, 1'b1, hhsd_pkg::STATUS_DROPPED}}
    };
    foreach (dir_table[i]) begin
      rx_stream.push_back(dir_table[i].rx);
      rx_typed.push_back(dir_table[i].typed);
      rx_typed_res.push_back(dir_table[i].res);
    end

    while (rx_stream.size() < DIR_ROWS + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_field(16'($urandom), LEN_DIGITS, 1'b1);
        add_field(16'($urandom), CHAN_DIGITS, $urandom_range(0, 3) == 0);
      end else if (r < 14) begin
        add_field(16'd0, LEN_DIGITS, 1'b0);
        add_field(16'($urandom), CHAN_DIGITS, $urandom_range(0, 2) == 0);
      end else begin
        if (r == 14) len = $urandom_range(100, 300);
        else if (r < 25) len = $urandom_range(9, 40);
        else len = $urandom_range(1, 8);
        add_field(16'(len), LEN_DIGITS, 1'b0);
        add_field(16'($urandom), CHAN_DIGITS, $urandom_range(0, 9) == 0);
        repeat (len) add_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rst_done = 1'b1;

    for (int i = 0; i < rx_stream.size(); i++) begin
      if (i >= HOLD_AT && i < HOLD_AT + HOLD_ITEMS) begin
        gap = 0;
      end else if (calm > 0) begin
        gap = 0;
        calm--;
      end else begin
        gap = idle_len();
        if ($urandom_range(0, 99) < 3) calm = $urandom_range(20, 60);
      end
      // keep offering while the result side holds off
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == PAUSE_AT || gap > 0) begin
        in_valid <= 1'b0;
        @(negedge clk);
        if (gap > 1) repeat (gap - 1) @(negedge clk);
        while (i == PAUSE_AT && pending_results.size() != 0) @(negedge clk);
      end
      send_idx = i;
      in_valid <= 1'b1;
      rx_byte  <= rx_stream[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    draining = 1'b1;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("hex_header_stream_deframer_tb passed");
    end else begin
      $display("hex_header_stream_deframer_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
